// ===== rtl/core/efa_pkg.sv =====
// Shared types, constants and codes of the event fragment assembler.
package efa_pkg;

	// Default table geometry.
	localparam int DESCRIPTORS_DEF = 8;
	localparam int SOURCES_DEF     = 64;

	// Field widths.
	localparam int SRC_W   = 6;
	localparam int ID_W    = 32;
	localparam int HLEN_W  = 16;
	localparam int RLEN_W  = 17;
	localparam int COUNT_W = 7;
	localparam int BYTES_W = 32;
	localparam int AGE_W   = 9;
	localparam int SEQ_W   = 32;
	localparam int SLOT_W  = 3;
	localparam int MASK_W  = 64;

	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 128;

	// Bytes of IP header included in the received length.
	localparam logic [RLEN_W-1:0]  IP_HDR_BYTES = 17'd20;
	localparam logic [COUNT_W-1:0] COUNT_MAX    = 7'd127;

	// Configuration register indexes and reset values.
	localparam logic [1:0] REG_SOURCE_COUNT = 2'd0;
	localparam logic [1:0] REG_AGE_START    = 2'd1;
	localparam logic [1:0] REG_DROP_INC     = 2'd2;
	localparam logic [1:0] REG_ZERO_MASK    = 2'd3;

	localparam logic [COUNT_W-1:0] SOURCE_COUNT_RST = 7'd64;
	localparam logic [AGE_W-1:0]   AGE_START_RST    = 9'd8;

	// Result kinds.
	localparam logic [1:0] KIND_ADDED   = 2'd0;
	localparam logic [1:0] KIND_EMITTED = 2'd1;
	localparam logic [1:0] KIND_DROPPED = 2'd2;
	localparam logic [1:0] KIND_NOTHING = 2'd3;

	// Configuration register set.
	typedef struct packed {
		logic [COUNT_W-1:0] source_count;
		logic [AGE_W-1:0]   age_start;
		logic               drop_incomplete;
		logic [MASK_W-1:0]  double_zero_mask;
	} cfg_t;

	// Datapath operations issued by the controller.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOOK,
		OP_AGE,
		OP_FORCE,
		OP_OPEN,
		OP_UPDATE,
		OP_COMPLETE,
		OP_DROP,
		OP_FL_SCAN,
		OP_FL_OUT
	} op_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
		logic is_flush;
		logic is_valid;
		logic hit;
		logic full;
		logic complete;
		logic fl_more;
	} status_t;

endpackage

// ===== rtl/core/efa_ctrl.sv =====
// Controller state machine that sequences lookup, ageing, update and flush.
module efa_ctrl #(
	parameter int DESCRIPTORS = efa_pkg::DESCRIPTORS_DEF,
	parameter int PTR_W       = (DESCRIPTORS > 1) ? $clog2(DESCRIPTORS) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_accept,
	input  efa_pkg::status_t    status,
	output logic                in_ready,
	output efa_pkg::op_t        op,
	output logic [PTR_W-1:0]    ptr
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_LOOK,
		ST_CHECK,
		ST_AGE,
		ST_FORCE,
		ST_OPEN,
		ST_UPDATE,
		ST_COMPLETE,
		ST_DROP,
		ST_FL_SCAN,
		ST_FL_OUT
	} state_t;

	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DESCRIPTORS - 1);

	state_t           state_q;
	logic [PTR_W-1:0] ptr_q;
	logic             ptr_last;

	assign ptr_last = (ptr_q == PTR_LAST);
	assign ptr      = ptr_q;
	assign in_ready = (state_q == ST_IDLE);

	// Operation issued in each state.
	always_comb begin
		op = efa_pkg::OP_NONE;
		unique case (state_q)
			ST_LOOK:     op = efa_pkg::OP_LOOK;
			ST_AGE:      op = efa_pkg::OP_AGE;
			ST_FORCE:    if (status.out_free) op = efa_pkg::OP_FORCE;
			ST_OPEN:     op = efa_pkg::OP_OPEN;
			ST_UPDATE:   if (status.out_free) op = efa_pkg::OP_UPDATE;
			ST_COMPLETE: if (status.out_free) op = efa_pkg::OP_COMPLETE;
			ST_DROP:     if (status.out_free) op = efa_pkg::OP_DROP;
			ST_FL_SCAN:  op = efa_pkg::OP_FL_SCAN;
			ST_FL_OUT:   if (status.out_free) op = efa_pkg::OP_FL_OUT;
			default:     op = efa_pkg::OP_NONE;
		endcase
	end

	// State and scan pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ptr_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					ptr_q <= '0;
					if (status.is_flush) state_q <= ST_FL_SCAN;
					else if (!status.is_valid) state_q <= ST_DROP;
					else state_q <= ST_LOOK;
				end
				ST_LOOK: begin
					if (ptr_last) begin
						ptr_q   <= '0;
						state_q <= ST_CHECK;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_CHECK: begin
					ptr_q   <= '0;
					state_q <= status.hit ? ST_UPDATE : ST_AGE;
				end
				ST_AGE: begin
					if (ptr_last) begin
						ptr_q   <= '0;
						state_q <= status.full ? ST_FORCE : ST_OPEN;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_FORCE: begin
					if (status.out_free) state_q <= ST_OPEN;
				end
				ST_OPEN: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (status.out_free) state_q <= status.complete ? ST_COMPLETE : ST_IDLE;
				end
				ST_COMPLETE: begin
					if (status.out_free) state_q <= ST_IDLE;
				end
				ST_DROP: begin
					if (status.out_free) state_q <= ST_IDLE;
				end
				ST_FL_SCAN: begin
					if (ptr_last) begin
						ptr_q   <= '0;
						state_q <= ST_FL_OUT;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_FL_OUT: begin
					if (status.out_free) state_q <= status.fl_more ? ST_FL_SCAN : ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/efa_dpath.sv =====
// Datapath: descriptor table, scan trackers, update arithmetic and result register.
module efa_dpath #(
	parameter int DESCRIPTORS = efa_pkg::DESCRIPTORS_DEF,
	parameter int SOURCES     = efa_pkg::SOURCES_DEF,
	parameter int PTR_W       = (DESCRIPTORS > 1) ? $clog2(DESCRIPTORS) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  efa_pkg::cfg_t                 cfg,
	input  efa_pkg::op_t                  op,
	input  logic [PTR_W-1:0]              ptr,
	input  logic                          in_accept,
	input  logic                          in_mode,
	input  logic [efa_pkg::SRC_W-1:0]     in_source_index,
	input  logic                          in_source_known,
	input  logic [efa_pkg::ID_W-1:0]      in_event_id,
	input  logic [efa_pkg::HLEN_W-1:0]    in_total_len,
	input  logic [efa_pkg::HLEN_W-1:0]    in_event_count,
	input  logic [efa_pkg::RLEN_W-1:0]    in_received_len,
	output efa_pkg::status_t              status,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [1:0]                    out_kind,
	output logic                          out_last,
	output logic [efa_pkg::OUT_DATA_W-1:0] out_data
);

	localparam int CNT_W = $clog2(DESCRIPTORS + 1);

	// Descriptor table.
	logic                         open_q  [DESCRIPTORS];
	logic [efa_pkg::ID_W-1:0]     id_q    [DESCRIPTORS];
	logic [efa_pkg::AGE_W-1:0]    age_q   [DESCRIPTORS];
	logic [SOURCES-1:0]           seen_q  [DESCRIPTORS];
	logic [efa_pkg::COUNT_W-1:0]  count_q [DESCRIPTORS];
	logic [efa_pkg::BYTES_W-1:0]  bytes_q [DESCRIPTORS];
	logic [efa_pkg::HLEN_W-1:0]   pack_q  [DESCRIPTORS];
	logic                         err_q   [DESCRIPTORS];

	// Captured item.
	logic                         mode_q;
	logic                         valid_q;
	logic [efa_pkg::SRC_W-1:0]    src_q;
	logic [efa_pkg::ID_W-1:0]     pid_q;
	logic [efa_pkg::HLEN_W-1:0]   tot_q;
	logic [efa_pkg::HLEN_W-1:0]   cntf_q;
	logic [efa_pkg::RLEN_W-1:0]   len_q;
	logic                         zfa_q;
	logic [efa_pkg::SEQ_W-1:0]    emit_cnt_q;

	// Scan trackers.
	logic                         hit_q;
	logic                         free_found_q;
	logic [PTR_W-1:0]             free_q;
	logic [PTR_W-1:0]             slot_q;
	logic                         cand_found_q;
	logic                         cand_zero_q;
	logic [PTR_W-1:0]             cand_q;
	logic [efa_pkg::AGE_W-1:0]    cand_age_q;
	logic [efa_pkg::ID_W-1:0]     cand_id_q;
	logic                         fl_found_q;
	logic [PTR_W-1:0]             fl_min_q;
	logic [efa_pkg::ID_W-1:0]     fl_min_id_q;
	logic [CNT_W-1:0]             fl_cnt_q;

	// Result register.
	logic                          ov_q;
	logic [1:0]                    okind_q;
	logic                          olast_q;
	logic [efa_pkg::OUT_DATA_W-1:0] odata_q;

	// Single read port into the table.
	logic [PTR_W-1:0]             addr;
	logic                         rd_open;
	logic [efa_pkg::ID_W-1:0]     rd_id;
	logic [efa_pkg::AGE_W-1:0]    rd_age;
	logic [SOURCES-1:0]           rd_seen;
	logic [efa_pkg::COUNT_W-1:0]  rd_count;
	logic [efa_pkg::BYTES_W-1:0]  rd_bytes;
	logic [efa_pkg::HLEN_W-1:0]   rd_pack;
	logic                         rd_err;

	always_comb begin
		case (op) inside
			efa_pkg::OP_FORCE:                         addr = cand_q;
			efa_pkg::OP_UPDATE, efa_pkg::OP_COMPLETE:  addr = slot_q;
			efa_pkg::OP_FL_OUT:                        addr = fl_min_q;
			default:                                   addr = ptr;
		endcase
	end

	assign rd_open  = open_q[addr];
	assign rd_id    = id_q[addr];
	assign rd_age   = age_q[addr];
	assign rd_seen  = seen_q[addr];
	assign rd_count = count_q[addr];
	assign rd_bytes = bytes_q[addr];
	assign rd_pack  = pack_q[addr];
	assign rd_err   = err_q[addr];

	// Source check and double-zero id fix on the incoming beat.
	logic                       in_valid;
	logic                       fix_en;
	logic [efa_pkg::ID_W-1:0]   in_id_fixed;
	logic                       zfa_set;

	assign in_valid = in_source_known
		&& (efa_pkg::COUNT_W'(in_source_index) < cfg.source_count)
		&& (efa_pkg::COUNT_W'(in_source_index) < efa_pkg::COUNT_W'(SOURCES));
	assign fix_en   = !in_mode && in_valid && cfg.double_zero_mask[in_source_index];
	assign zfa_set  = fix_en && (in_event_id == '0) && !zfa_q;
	assign in_id_fixed = (fix_en && zfa_q) ? in_event_id + 1'b1 : in_event_id;

	// Ageing step.
	logic [efa_pkg::AGE_W-1:0] age_new;
	logic                      age_zero;
	logic                      cand_take;

	assign age_new  = (rd_age > efa_pkg::AGE_W'(1)) ? rd_age - 1'b1 : '0;
	assign age_zero = (age_new == '0);

	always_comb begin
		if (!cand_found_q) cand_take = 1'b1;
		else if (age_zero) cand_take = !cand_zero_q || (rd_id > cand_id_q);
		else if (cand_zero_q) cand_take = 1'b0;
		else cand_take = (age_new < cand_age_q)
			|| ((age_new == cand_age_q) && (rd_id < cand_id_q));
	end

	// Packet update arithmetic.
	logic                        count0;
	logic                        dup;
	logic [efa_pkg::HLEN_W-1:0]  pack1;
	logic [efa_pkg::HLEN_W-1:0]  pack2;
	logic [efa_pkg::HLEN_W-1:0]  pkt_count;
	logic [efa_pkg::BYTES_W-1:0] bytes_new;
	logic                        len_bad_tot;
	logic                        len_bad_cnt;
	logic                        swp;
	logic [efa_pkg::COUNT_W-1:0] count_new;
	logic                        err_new;
	logic [SOURCES-1:0]          src_bit;
	logic                        complete;

	assign src_bit     = SOURCES'(1) << src_q;
	assign count0      = (rd_count == '0);
	assign dup         = |(rd_seen & src_bit);
	assign pack1       = count0 ? cntf_q : rd_pack;
	assign bytes_new   = rd_bytes + efa_pkg::BYTES_W'(len_q);
	assign len_bad_tot = (len_q != efa_pkg::RLEN_W'(tot_q) + efa_pkg::IP_HDR_BYTES);
	assign len_bad_cnt = (len_q != efa_pkg::RLEN_W'(cntf_q) + efa_pkg::IP_HDR_BYTES);
	assign swp         = len_bad_tot && !len_bad_cnt;
	assign pkt_count   = swp ? tot_q : cntf_q;
	assign pack2       = (swp && count0) ? tot_q : pack1;
	assign count_new   = (rd_count < efa_pkg::COUNT_MAX) ? rd_count + 1'b1 : rd_count;
	assign err_new     = rd_err || dup || (len_bad_tot && len_bad_cnt) || (pack2 != pkt_count);
	assign complete    = (count_new >= cfg.source_count);

	// Emitted descriptor fields.
	logic                        emit_inc;
	logic                        emit_err;
	logic [31:0]                 addr_wide;
	logic [efa_pkg::SLOT_W-1:0]  out_slot;
	logic                        do_emit;

	assign emit_inc  = (rd_count != cfg.source_count);
	assign emit_err  = rd_err || (emit_inc && cfg.drop_incomplete);
	assign addr_wide = 32'(addr);
	assign out_slot  = addr_wide[efa_pkg::SLOT_W-1:0];
	assign do_emit   = (op == efa_pkg::OP_FORCE) || (op == efa_pkg::OP_COMPLETE)
		|| ((op == efa_pkg::OP_FL_OUT) && (fl_cnt_q != '0));

	// Status to the controller.
	assign status.out_free = !ov_q || out_ready;
	assign status.is_flush = mode_q;
	assign status.is_valid = valid_q;
	assign status.hit      = hit_q;
	assign status.full     = !free_found_q;
	assign status.complete = complete;
	assign status.fl_more  = (fl_cnt_q > CNT_W'(1));

	assign out_valid = ov_q;
	assign out_kind  = okind_q;
	assign out_last  = olast_q;
	assign out_data  = odata_q;

	// Control state: open bits, trackers, counters, result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DESCRIPTORS; i++) open_q[i] <= 1'b0;
			zfa_q        <= 1'b0;
			emit_cnt_q   <= '0;
			ov_q         <= 1'b0;
			mode_q       <= 1'b0;
			valid_q      <= 1'b0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			cand_found_q <= 1'b0;
			cand_zero_q  <= 1'b0;
			fl_found_q   <= 1'b0;
			fl_cnt_q     <= '0;
		end else begin
			if (in_accept) begin
				mode_q       <= in_mode;
				valid_q      <= in_valid;
				hit_q        <= 1'b0;
				free_found_q <= 1'b0;
				cand_found_q <= 1'b0;
				cand_zero_q  <= 1'b0;
				fl_found_q   <= 1'b0;
				fl_cnt_q     <= '0;
				if (zfa_set) zfa_q <= 1'b1;
			end
			case (op)
				efa_pkg::OP_LOOK: begin
					if (rd_open && (rd_id == pid_q) && !hit_q) hit_q <= 1'b1;
					if (!rd_open && !free_found_q) free_found_q <= 1'b1;
				end
				efa_pkg::OP_AGE: begin
					if (rd_open && cand_take) begin
						cand_found_q <= 1'b1;
						cand_zero_q  <= age_zero;
					end
				end
				efa_pkg::OP_OPEN: begin
					open_q[free_found_q ? free_q : cand_q] <= 1'b1;
				end
				efa_pkg::OP_FL_SCAN: begin
					if (rd_open) begin
						fl_cnt_q <= fl_cnt_q + 1'b1;
						if (!fl_found_q || (rd_id < fl_min_id_q)) fl_found_q <= 1'b1;
					end
				end
				efa_pkg::OP_FL_OUT: begin
					fl_cnt_q   <= '0;
					fl_found_q <= 1'b0;
				end
				default: ;
			endcase
			if (do_emit) begin
				open_q[addr] <= 1'b0;
				emit_cnt_q   <= emit_cnt_q + 1'b1;
			end
			// A new result is loaded, otherwise a taken one leaves the register.
			if ((op == efa_pkg::OP_UPDATE) || (op == efa_pkg::OP_DROP) || do_emit
				|| (op == efa_pkg::OP_FL_OUT)) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// Payload: captured item, tracker indexes, table entries and result fields.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			src_q  <= in_source_index;
			pid_q  <= in_id_fixed;
			tot_q  <= in_total_len;
			cntf_q <= in_event_count;
			len_q  <= in_received_len;
		end
		case (op)
			efa_pkg::OP_LOOK: begin
				if (rd_open && (rd_id == pid_q) && !hit_q) slot_q <= addr;
				if (!rd_open && !free_found_q) free_q <= addr;
			end
			efa_pkg::OP_AGE: begin
				if (rd_open) begin
					age_q[addr] <= age_new;
					if (cand_take) begin
						cand_q     <= addr;
						cand_age_q <= age_new;
						cand_id_q  <= rd_id;
					end
				end
			end
			efa_pkg::OP_OPEN: begin
				slot_q                                  <= free_found_q ? free_q : cand_q;
				id_q[free_found_q ? free_q : cand_q]    <= pid_q;
				age_q[free_found_q ? free_q : cand_q]   <= cfg.age_start;
				seen_q[free_found_q ? free_q : cand_q]  <= '0;
				count_q[free_found_q ? free_q : cand_q] <= '0;
				bytes_q[free_found_q ? free_q : cand_q] <= '0;
				pack_q[free_found_q ? free_q : cand_q]  <= '0;
				err_q[free_found_q ? free_q : cand_q]   <= 1'b0;
			end
			efa_pkg::OP_UPDATE: begin
				seen_q[addr]  <= rd_seen | src_bit;
				count_q[addr] <= count_new;
				bytes_q[addr] <= bytes_new;
				pack_q[addr]  <= pack2;
				err_q[addr]   <= err_new;
				okind_q <= efa_pkg::KIND_ADDED;
				olast_q <= !complete;
				odata_q <= {3'b000, {efa_pkg::SEQ_W{1'b0}}, swp, 1'b0, err_new, pack2,
					bytes_new, count_new, rd_id, out_slot};
			end
			efa_pkg::OP_FL_SCAN: begin
				if (rd_open && (!fl_found_q || (rd_id < fl_min_id_q))) begin
					fl_min_q    <= addr;
					fl_min_id_q <= rd_id;
				end
			end
			efa_pkg::OP_DROP: begin
				okind_q <= efa_pkg::KIND_DROPPED;
				olast_q <= 1'b1;
				odata_q <= '0;
			end
			efa_pkg::OP_FL_OUT: begin
				if (fl_cnt_q == '0) begin
					okind_q <= efa_pkg::KIND_NOTHING;
					olast_q <= 1'b1;
					odata_q <= '0;
				end
			end
			default: ;
		endcase
		if (do_emit) begin
			okind_q <= efa_pkg::KIND_EMITTED;
			olast_q <= (op == efa_pkg::OP_COMPLETE)
				|| ((op == efa_pkg::OP_FL_OUT) && (fl_cnt_q == CNT_W'(1)));
			odata_q <= {3'b000, emit_cnt_q, 1'b0, emit_inc, emit_err, rd_pack,
				rd_bytes, rd_count, rd_id, out_slot};
		end
	end

endmodule

// ===== rtl/core/event_fragment_assembler.sv =====
// Top level of the event fragment assembler: register port, stream ports and assertions.
//
// Packet headers from up to SOURCES sources are gathered into DESCRIPTORS open event
// descriptors; results come out one beat at a time, the last beat of each input item
// carrying tlast. One item is handled at a time. The descriptor table has a single read
// port that is walked one entry per cycle. A packet is looked up in the whole table; one
// that opens a new event first ages every open entry, forces an event out if the table
// is full and then opens its own; an event that completes is emitted after the update.
// A rejected packet yields a drop result, and a flush walks the table once before each
// open event it emits, or once before an empty result when none is open. Stalls on the
// result side hold the sequence. A result waits in an output register; the next packet
// header is taken once the previous item's last result has been loaded there.
module event_fragment_assembler #(
	parameter int DESCRIPTORS = efa_pkg::DESCRIPTORS_DEF,
	parameter int SOURCES     = efa_pkg::SOURCES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Register port.
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [4:0]                     paddr,
	input  logic [63:0]                    pwdata,
	output logic [63:0]                    prdata,
	output logic                           pready,
	// Input stream.
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// source_index[5:0], source_known[6], event_id[38:7], header_total_len[54:39],
	// header_event_count[70:55], received_len[87:71]
	input  logic [efa_pkg::IN_DATA_W-1:0]  s_tdata,
	// mode[0]
	input  logic                           s_tuser,
	// Output stream.
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// slot[2:0], out_event_id[34:3], sources_received[41:35], payload_bytes[73:42],
	// pack_factor[89:74], error_flag[90], incomplete_flag[91], swap_fixed[92],
	// emit_sequence[124:93], zero fill[127:125]
	output logic [efa_pkg::OUT_DATA_W-1:0] m_tdata,
	// result_kind[1:0]
	output logic [1:0]                     m_tuser,
	output logic                           m_tlast
);

	localparam int PTR_W = (DESCRIPTORS > 1) ? $clog2(DESCRIPTORS) : 1;

	efa_pkg::cfg_t     cfg_q;
	efa_pkg::status_t  status;
	efa_pkg::op_t      op;
	logic [PTR_W-1:0]  ptr;
	logic              in_accept;
	logic              cfg_wr;
	logic [1:0]        reg_idx;

	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign reg_idx   = paddr[4:3];
	assign in_accept = s_tvalid && s_tready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.source_count     <= efa_pkg::SOURCE_COUNT_RST;
			cfg_q.age_start        <= efa_pkg::AGE_START_RST;
			cfg_q.drop_incomplete  <= 1'b0;
			cfg_q.double_zero_mask <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				efa_pkg::REG_SOURCE_COUNT: cfg_q.source_count <= pwdata[efa_pkg::COUNT_W-1:0];
				efa_pkg::REG_AGE_START:    cfg_q.age_start <= pwdata[efa_pkg::AGE_W-1:0];
				efa_pkg::REG_DROP_INC:     cfg_q.drop_incomplete <= pwdata[0];
				efa_pkg::REG_ZERO_MASK:    cfg_q.double_zero_mask <= pwdata;
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (reg_idx)
			efa_pkg::REG_SOURCE_COUNT: prdata = 64'(cfg_q.source_count);
			efa_pkg::REG_AGE_START:    prdata = 64'(cfg_q.age_start);
			efa_pkg::REG_DROP_INC:     prdata = 64'(cfg_q.drop_incomplete);
			efa_pkg::REG_ZERO_MASK:    prdata = cfg_q.double_zero_mask;
			default:                   prdata = '0;
		endcase
	end

	efa_ctrl #(
		.DESCRIPTORS (DESCRIPTORS),
		.PTR_W       (PTR_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.status    (status),
		.in_ready  (s_tready),
		.op        (op),
		.ptr       (ptr)
	);

	efa_dpath #(
		.DESCRIPTORS (DESCRIPTORS),
		.SOURCES     (SOURCES),
		.PTR_W       (PTR_W)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.op              (op),
		.ptr             (ptr),
		.in_accept       (in_accept),
		.in_mode         (s_tuser),
		.in_source_index (s_tdata[5:0]),
		.in_source_known (s_tdata[6]),
		.in_event_id     (s_tdata[38:7]),
		.in_total_len    (s_tdata[54:39]),
		.in_event_count  (s_tdata[70:55]),
		.in_received_len (s_tdata[87:71]),
		.status          (status),
		.out_ready       (m_tready),
		.out_valid       (m_tvalid),
		.out_kind        (m_tuser),
		.out_last        (m_tlast),
		.out_data        (m_tdata)
	);

	// A dropped packet or an empty flush yields exactly one beat.
	a_single_beat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ((m_tuser == efa_pkg::KIND_DROPPED) || (m_tuser == efa_pkg::KIND_NOTHING))
		|-> m_tlast)
		else $error("drop or empty flush result without tlast");

	// Only one item is in work at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> !s_tready)
		else $error("input taken while an item is in work");

	// Result fields that carry no meaning stay zero.
	a_add_no_seq: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == efa_pkg::KIND_ADDED)
		|-> ((m_tdata[124:93] == '0) && !m_tdata[91]))
		else $error("added-packet result carries emit fields");

endmodule
